// ===== rtl/core/byte_stuffed_frame_receiver_defines.svh =====
// Assertion macros shared by the frame receiver RTL.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef BYTE_STUFFED_FRAME_RECEIVER_DEFINES_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSFR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bsfr_pkg.sv =====
// Types and constants for the byte-stuffed frame receiver.
// No dependencies; used by byte_stuffed_frame_receiver.
package bsfr_pkg;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_DONE   = 3'd1,
    KIND_JUNK_S = 3'd2,
    KIND_JUNK_E = 3'd3,
    KIND_JUNK_T = 3'd4,
    KIND_OVER   = 3'd5
  } kind_t;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_START   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_END     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ESCAPE  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 2'd3;

  localparam logic [7:0]  START_RST   = 8'd0;
  localparam logic [7:0]  END_RST     = 8'd1;
  localparam logic [7:0]  ESCAPE_RST  = 8'd2;
  localparam logic [15:0] TIMEOUT_RST = 16'd200;

  // One result word as held in the output queue.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_v;
    logic [9:0]  count;
    logic        last;
  } res_t;

endpackage

// ===== rtl/core/byte_stuffed_frame_receiver.sv =====
// Byte-stuffed frame receiver: start/end/escape deframer with junk, timeout
// and overflow reporting. Depends on bsfr_pkg and the defines header.
//
// Channel  | Dir | tdata (low bit up)                 | tuser     | tlast
// ---------+-----+------------------------------------+-----------+----------------
// in_      | in  | rx_byte[7:0]                       | action    | -
// out_     | out | out_byte[7:0], byte_count[17:8]    | kind[2:0] | last of an input
// cfg_     | in  | we / addr / wdata, write only      | -         | -
//
// Each word is decoded in the cycle it is accepted; its zero, one or two
// results land in a 4-entry output queue and reach out_ in order behind any queued ones.
// One input word per cycle is sustained while the sink takes one result per
// cycle; in_tready drops only when the queue has fewer than two free slots.
// Reset (rst_n, synchronous) clears frame state, idle counter, queue and
// restores the code registers to their defaults.
`include "byte_stuffed_frame_receiver_defines.svh"

module byte_stuffed_frame_receiver #(
  parameter int HOLD_BYTES = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  input  logic                           in_tuser,   // [0] action: 0 byte, 1 tick
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // [7:0] out_byte, [17:8] byte_count
  output logic [2:0]                     out_tuser,  // [2:0] kind
  output logic                           out_tlast,
  // configuration
  input  logic                           cfg_we,
  input  logic [bsfr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bsfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(HOLD_BYTES + 1);
  localparam logic [CNT_W-1:0] HOLD_CNT = CNT_W'(HOLD_BYTES);
  localparam int Q_DEPTH = 4;
  localparam int QP_W = $clog2(Q_DEPTH);
  localparam int QC_W = $clog2(Q_DEPTH + 1);
  localparam logic [QC_W-1:0] Q_ROOM = QC_W'(Q_DEPTH - 2);

  // Counts go out modulo 1024.
  function automatic logic [9:0] to_cnt10(input logic [CNT_W-1:0] v);
    logic [CNT_W+9:0] w;
    w = {10'b0, v};
    return w[9:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [7:0]  start_r, end_r, escape_r;
  logic [15:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= bsfr_pkg::START_RST;
      end_r     <= bsfr_pkg::END_RST;
      escape_r  <= bsfr_pkg::ESCAPE_RST;
      timeout_r <= bsfr_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bsfr_pkg::REG_START:   start_r   <= cfg_wdata[7:0];
        bsfr_pkg::REG_END:     end_r     <= cfg_wdata[7:0];
        bsfr_pkg::REG_ESCAPE:  escape_r  <= cfg_wdata[7:0];
        bsfr_pkg::REG_TIMEOUT: timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ----------------------------------------------------------- frame state
  logic             in_frame_r, in_frame_nxt;
  logic             esc_pend_r, esc_pend_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0] flen_r, flen_nxt;
  logic [15:0]      idle_r, idle_nxt;

  logic             in_fire;
  bsfr_pkg::res_t   res0, res1;
  logic [1:0]       n_res;
  logic [7:0]       rx_b;
  logic [CNT_W-1:0] held_inc, flen_inc;

  assign in_fire  = in_tvalid && in_tready;
  assign rx_b     = in_tdata;
  assign held_inc = held_r + 1'b1;   // held_r < HOLD_BYTES whenever used
  assign flen_inc = flen_r + 1'b1;

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_pend_nxt = esc_pend_r;
    held_nxt     = held_r;
    flen_nxt     = flen_r;
    idle_nxt     = idle_r;
    res0         = '0;
    res1         = '0;
    n_res        = 2'd0;

    if (in_fire) begin
      if (in_tuser) begin
        // millisecond tick: saturating idle count, timeout drops held bytes
        if (idle_r != 16'hFFFF) idle_nxt = idle_r + 16'd1;
        if (held_r != '0 && idle_nxt > timeout_r) begin
          res0.kind  = bsfr_pkg::KIND_JUNK_T;
          res0.count = to_cnt10(held_r);
          n_res      = 2'd1;
          in_frame_nxt = 1'b0;
          esc_pend_nxt = 1'b0;
          held_nxt     = '0;
          flen_nxt     = '0;
        end
      end else if (held_r >= HOLD_CNT) begin
        // hold space full: drop the byte, flush the held bytes and frame state
        res0.kind  = bsfr_pkg::KIND_OVER;
        res0.count = to_cnt10(held_r);
        n_res      = 2'd1;
        in_frame_nxt = 1'b0;
        esc_pend_nxt = 1'b0;
        held_nxt     = '0;
        flen_nxt     = '0;
      end else begin
        idle_nxt = '0;
        if (rx_b == start_r) begin
          if (held_r != '0) begin
            res0.kind  = bsfr_pkg::KIND_JUNK_S;
            res0.count = to_cnt10(held_r);
            n_res      = 2'd1;
          end
          in_frame_nxt = 1'b1;
          esc_pend_nxt = 1'b0;
          held_nxt     = CNT_W'(1);
          flen_nxt     = '0;
        end else if (rx_b == end_r) begin
          if (in_frame_r) begin
            if (esc_pend_r) begin
              // trailing escape goes out raw, then the marker
              res0.kind   = bsfr_pkg::KIND_DATA;
              res0.byte_v = escape_r;
              res1.kind   = bsfr_pkg::KIND_DONE;
              res1.count  = to_cnt10(flen_inc);
              n_res       = 2'd2;
            end else begin
              res0.kind  = bsfr_pkg::KIND_DONE;
              res0.count = to_cnt10(flen_r);
              n_res      = 2'd1;
            end
          end else begin
            res0.kind  = bsfr_pkg::KIND_JUNK_E;
            res0.count = to_cnt10(held_inc);
            n_res      = 2'd1;
          end
          in_frame_nxt = 1'b0;
          esc_pend_nxt = 1'b0;
          held_nxt     = '0;
          flen_nxt     = '0;
        end else begin
          held_nxt = held_inc;
          if (in_frame_r) begin
            if (esc_pend_r) begin
              esc_pend_nxt = 1'b0;
              res0.kind    = bsfr_pkg::KIND_DATA;
              res0.byte_v  = rx_b + start_r;
              n_res        = 2'd1;
              flen_nxt     = flen_inc;
            end else if (rx_b == escape_r) begin
              esc_pend_nxt = 1'b1;
            end else begin
              res0.kind   = bsfr_pkg::KIND_DATA;
              res0.byte_v = rx_b;
              n_res       = 2'd1;
              flen_nxt    = flen_inc;
            end
          end
        end
      end
    end

    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_pend_r <= 1'b0;
      held_r     <= '0;
      flen_r     <= '0;
      idle_r     <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      esc_pend_r <= esc_pend_nxt;
      held_r     <= held_nxt;
      flen_r     <= flen_nxt;
      idle_r     <= idle_nxt;
    end
  end

  // ----------------------------------------------------------- result queue
  bsfr_pkg::res_t    q_r [Q_DEPTH];
  logic [QP_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]   cnt_r, cnt_nxt;
  logic              out_fire;
  logic [QP_W-1:0]   wr_ptr_p1;
  bsfr_pkg::res_t    head;

  assign out_fire   = out_tvalid && out_tready;
  assign wr_ptr_p1  = wr_ptr_r + 1'b1;
  assign wr_ptr_nxt = wr_ptr_r + QP_W'(n_res);
  assign rd_ptr_nxt = rd_ptr_r + QP_W'(out_fire);
  assign cnt_nxt    = cnt_r + QC_W'(n_res) - QC_W'(out_fire);

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) q_r[wr_ptr_r]  <= res0;
    if (n_res == 2'd2) q_r[wr_ptr_p1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // room for the worst case of two results
  assign in_tready  = (cnt_r <= Q_ROOM);
  assign head       = q_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {6'b0, head.count, head.byte_v};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

  // ------------------------------------------------------------- assertions
  `BSFR_ASSERT_IMPLY(a_esc_in_frame, !in_frame_r, !esc_pend_r, "escape pending outside a frame")
  `BSFR_ASSERT_IMPLY(a_flen_below_held, in_frame_r, flen_r < held_r, "frame length not below held count")
  `BSFR_ASSERT_IMPLY(a_held_bound, 1'b1, held_r <= HOLD_CNT, "held count beyond hold space")
  `BSFR_ASSERT_NEXT(a_queue_bound, in_fire, cnt_r <= QC_W'(Q_DEPTH), "result queue overrun")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for byte_stuffed_frame_receiver: directed and random byte/tick
// streams against a cycle-free deframer model, results compared word by word.
// Depends on bsfr_pkg and the byte_stuffed_frame_receiver RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_BYTES   = 512;
  localparam int DRAIN_CYCLES = 6;   // results are registered into the output queue; keep slack
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // One stimulus word: action on tuser, rx_byte on tdata.
  typedef struct packed {
    logic       is_tick;
    logic [7:0] rx;
  } rx_word_t;

  // One decoded result as the sink should see it.
  typedef struct packed {
    bsfr_pkg::kind_t kind;
    logic [7:0]      data_byte;
    logic [9:0]      count;
    logic            last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic                            cfg_we = 1'b0;
  logic [bsfr_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [bsfr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Words waiting for the driver, results waiting for the sink.
  rx_word_t      pending_words[$];
  frame_result_t expected_results[$];

  // Model copy of the code registers (reset values from the package).
  logic [7:0] code_start  = bsfr_pkg::START_RST;
  logic [7:0] code_end    = bsfr_pkg::END_RST;
  logic [7:0] code_escape = bsfr_pkg::ESCAPE_RST;
  int         idle_limit  = int'(bsfr_pkg::TIMEOUT_RST);

  // Model copy of the deframer state.
  bit rx_in_frame;
  bit rx_escape_pending;
  int rx_held;
  int rx_frame_len;
  int rx_idle;

  int  words_queued;
  int  words_accepted;
  int  results_checked;
  int  kind_seen[6];
  int  settings_used = 1;
  int  fail_count;
  bit  fast_feed;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  byte_stuffed_frame_receiver #(
    .HOLD_BYTES(HOLD_BYTES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] rx_byte
    .in_tuser   (in_tuser),    // [0] action: byte or tick
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] out_byte, [17:8] byte_count, [23:18] zero
    .out_tuser  (out_tuser),   // [2:0] kind
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Deframer model
  // ---------------------------------------------------------------------------

  function automatic frame_result_t make_result(bsfr_pkg::kind_t k, logic [7:0] b, int n);
    frame_result_t r;
    r.kind      = k;
    r.data_byte = b;
    r.count     = n[9:0];   // counts wrap at 10 bits
    r.last      = 1'b0;
    return r;
  endfunction

  task automatic drop_frame();
    rx_in_frame       = 1'b0;
    rx_escape_pending = 1'b0;
    rx_held           = 0;
    rx_frame_len      = 0;
  endtask

  // Runs one accepted word through the model and queues what it produces.
  task automatic decode_word(input logic is_tick, input logic [7:0] rx);
    frame_result_t step_q[$];
    if (is_tick == ACT_TICK) begin
      if (rx_idle < 65535) rx_idle++;
      if (rx_held > 0 && rx_idle > idle_limit) begin
        step_q.insert(step_q.size(), make_result(bsfr_pkg::KIND_JUNK_T, 8'h00, rx_held));
        drop_frame();
      end
    end else if (rx_held + 1 > HOLD_BYTES) begin
      // buffer full: the byte is dropped, idle counter untouched
      step_q.insert(step_q.size(), make_result(bsfr_pkg::KIND_OVER, 8'h00, rx_held));
      drop_frame();
    end else begin
      rx_idle = 0;
      if (rx == code_start) begin
        // start wins over end and escape
        if (rx_held > 0)
          step_q.insert(step_q.size(), make_result(bsfr_pkg::KIND_JUNK_S, 8'h00, rx_held));
        drop_frame();
        rx_in_frame = 1'b1;
        rx_held     = 1;
      end else if (rx == code_end) begin
        if (rx_in_frame) begin
          if (rx_escape_pending) begin
            // dangling escape is passed through raw
            step_q.insert(step_q.size(), make_result(bsfr_pkg::KIND_DATA, code_escape, 0));
            rx_frame_len++;
          end
          step_q.insert(step_q.size(), make_result(bsfr_pkg::KIND_DONE, 8'h00, rx_frame_len));
        end else begin
          step_q.insert(step_q.size(), make_result(bsfr_pkg::KIND_JUNK_E, 8'h00, rx_held + 1));
        end
        drop_frame();
      end else begin
        rx_held++;
        if (rx_in_frame) begin
          if (rx_escape_pending) begin
            rx_escape_pending = 1'b0;
            step_q.insert(step_q.size(),
                          make_result(bsfr_pkg::KIND_DATA, rx + code_start, 0));
            rx_frame_len++;
          end else if (rx == code_escape) begin
            rx_escape_pending = 1'b1;
          end else begin
            step_q.insert(step_q.size(), make_result(bsfr_pkg::KIND_DATA, rx, 0));
            rx_frame_len++;
          end
        end
      end
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) expected_results.insert(expected_results.size(), step_q[i]);
  endtask

  // Gap length: mostly none, some short, a few long; zero in a calm stretch.
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one word per handshake, random gaps between words
  // ---------------------------------------------------------------------------
  int       in_gap;
  int       in_stretch;
  bit       in_calm;
  rx_word_t next_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_word(in_tuser, in_tdata);
        words_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= next_word.is_tick;
          in_tdata  <= next_word.rx;
          // alternate calm stretches with gappy ones
          if (in_stretch == 0) begin
            in_stretch = $urandom_range(20, 80);
            in_calm    = ($urandom_range(0, 3) == 0);
          end
          in_stretch--;
          in_gap = pick_gap(in_calm || fast_feed);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random backpressure, each accepted word checked in order
  // ---------------------------------------------------------------------------
  int            out_stall;
  int            out_stretch;
  bit            out_calm;
  frame_result_t want;

  function automatic void check_field(input string name, input logic [15:0] want_v,
                                      input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: kind %0d, tdata %h, last %b",
                 out_tuser, out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_tuser));
          check_field("out_byte", 16'(want.data_byte), 16'(out_tdata[7:0]));
          check_field("byte_count", 16'(want.count), 16'(out_tdata[17:8]));
          check_field("last", 16'(want.last), 16'(out_tlast));
          check_field("tdata padding", 16'd0, {10'd0, out_tdata[23:18]});
          results_checked++;
          kind_seen[want.kind]++;
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_stretch == 0) begin
          out_stretch = $urandom_range(20, 80);
          out_calm    = ($urandom_range(0, 3) == 0);
        end
        out_stretch--;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_word(input logic is_tick, input logic [7:0] rx);
    rx_word_t w;
    w.is_tick = is_tick;
    w.rx      = rx;
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endtask

  // Frame payload byte, escaped when it collides with a code.
  task automatic push_data(input logic [7:0] d);
    if (d == code_start || d == code_end || d == code_escape) begin
      push_word(ACT_BYTE, code_escape);
      push_word(ACT_BYTE, d - code_start);
    end else begin
      push_word(ACT_BYTE, d);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return code_start;
      1: return code_end;
      2: return code_escape;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Blocks until every queued word is taken and every result has come back.
  task automatic wait_idle();
    do @(posedge clk);
    while (words_accepted != words_queued || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bsfr_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      bsfr_pkg::REG_START:   code_start  = value[7:0];
      bsfr_pkg::REG_END:     code_end    = value[7:0];
      bsfr_pkg::REG_ESCAPE:  code_escape = value[7:0];
      bsfr_pkg::REG_TIMEOUT: idle_limit  = int'(value);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_codes(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x,
                           input logic [15:0] t);
    write_reg(bsfr_pkg::REG_START, {8'd0, s});
    write_reg(bsfr_pkg::REG_END, {8'd0, e});
    write_reg(bsfr_pkg::REG_ESCAPE, {8'd0, x});
    write_reg(bsfr_pkg::REG_TIMEOUT, t);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          ph;
    int          len;
    int          phase_end;
    logic [7:0]  s, e, x;
    logic [15:0] t;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset codes: start 00, end 01, escape 02, timeout 200.
    push_word(ACT_TICK, 8'hA5);            // tick with nothing held
    push_word(ACT_BYTE, 8'h55);            // junk, then end outside a frame
    push_word(ACT_BYTE, 8'hAA);
    push_word(ACT_BYTE, 8'h01);
    push_word(ACT_BYTE, 8'h00);            // frame with plain and escaped byte
    push_word(ACT_BYTE, 8'hFF);
    push_word(ACT_BYTE, 8'h02);
    push_word(ACT_BYTE, 8'hFE);
    push_word(ACT_BYTE, 8'h01);
    push_word(ACT_BYTE, 8'h00);            // empty frame
    push_word(ACT_BYTE, 8'h01);
    push_word(ACT_BYTE, 8'h00);            // escape right before end is kept raw
    push_word(ACT_BYTE, 8'h33);
    push_word(ACT_BYTE, 8'h02);
    push_word(ACT_BYTE, 8'h01);
    push_word(ACT_BYTE, 8'h00);            // start inside an open frame
    push_word(ACT_BYTE, 8'h44);
    push_word(ACT_BYTE, 8'h00);
    push_word(ACT_BYTE, 8'h01);
    push_word(ACT_BYTE, 8'h77);            // junk before a start
    push_word(ACT_BYTE, 8'h00);
    push_word(ACT_BYTE, 8'h01);
    push_word(ACT_BYTE, 8'h02);            // escape outside a frame is junk
    push_word(ACT_BYTE, 8'h01);
    push_word(ACT_BYTE, 8'h00);            // escape then start
    push_word(ACT_BYTE, 8'h02);
    push_word(ACT_BYTE, 8'h00);
    push_word(ACT_BYTE, 8'h01);
    wait_idle();

    // Timeout of 1, escape offset that wraps past 255.
    set_codes(8'hF0, 8'h0F, 8'h7D, 16'd1);
    push_word(ACT_BYTE, 8'h20);            // held junk expires on second tick
    push_word(ACT_TICK, 8'h00);
    push_word(ACT_TICK, 8'hFF);
    push_word(ACT_TICK, 8'h00);
    push_word(ACT_BYTE, 8'hF0);            // open frame expires too
    push_word(ACT_BYTE, 8'h21);
    push_word(ACT_TICK, 8'h00);
    push_word(ACT_TICK, 8'h00);
    push_word(ACT_BYTE, 8'hF0);
    push_word(ACT_BYTE, 8'h7D);
    push_word(ACT_BYTE, 8'h20);            // 0x20 + 0xF0 wraps to 0x10
    push_word(ACT_TICK, 8'h00);            // a single tick does not expire
    push_word(ACT_BYTE, 8'h0F);
    wait_idle();

    // All codes equal at the top value, timeout disabled: held bytes never expire.
    set_codes(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    push_word(ACT_BYTE, 8'hFF);
    push_word(ACT_BYTE, 8'h00);
    push_word(ACT_BYTE, 8'hFF);
    repeat (4) push_word(ACT_TICK, 8'($urandom_range(0, 255)));
    wait_idle();
    write_reg(bsfr_pkg::REG_TIMEOUT, 16'd3);
    push_word(ACT_TICK, 8'h00);            // idle count now exceeds the lowered limit
    wait_idle();

    // Buffer limit: a frame fills the hold space, the next byte overflows.
    set_codes(8'h00, 8'hFF, 8'h80, 16'hFFFF);
    fast_feed = 1'b1;
    push_word(ACT_BYTE, 8'h00);
    repeat (HOLD_BYTES - 1) push_word(ACT_BYTE, 8'($urandom_range(1, 8'h7F)));
    push_word(ACT_BYTE, 8'h55);
    push_word(ACT_BYTE, 8'hFF);
    wait_idle();
    fast_feed = 1'b0;

    // Random part: new codes per phase, mostly well-formed frames plus noise.
    for (ph = 0; ph < 5; ph++) begin
      s = 8'($urandom_range(0, 255));
      e = 8'($urandom_range(0, 255));
      x = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
        0: e = s;
        1: x = e;
        2: x = s;
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0, 1, 2: t = 16'($urandom_range(1, 6));
        3:       t = 16'd1;
        4:       t = 16'($urandom_range(7, 300));
        default: t = 16'hFFFF;
      endcase
      set_codes(s, e, x, t);
      phase_end = words_queued + 8;
      while (words_queued < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            push_word(ACT_BYTE, code_start);
            len = $urandom_range(0, 12);
            repeat (len) push_data(pick_byte());
            if ($urandom_range(0, 7) == 0) push_word(ACT_BYTE, code_escape);
            if ($urandom_range(0, 9) != 0) push_word(ACT_BYTE, code_end);
          end
          6: repeat ($urandom_range(1, 5)) push_word(ACT_BYTE, pick_byte());
          7: repeat ($urandom_range(1, 8))
               push_word(ACT_TICK, 8'($urandom_range(0, 255)));
          default:
            repeat ($urandom_range(1, 4)) push_word(1'($urandom_range(0, 1)), pick_byte());
        endcase
      end
      wait_idle();
    end

    $display("covered %0d input words over %0d code settings; %0d results checked",
             words_accepted, settings_used, results_checked);
    $display("  data %0d, frames %0d, junk %0d/%0d/%0d, overflow %0d",
             kind_seen[bsfr_pkg::KIND_DATA], kind_seen[bsfr_pkg::KIND_DONE],
             kind_seen[bsfr_pkg::KIND_JUNK_S], kind_seen[bsfr_pkg::KIND_JUNK_E],
             kind_seen[bsfr_pkg::KIND_JUNK_T], kind_seen[bsfr_pkg::KIND_OVER]);
    if (fail_count == 0) begin
      $display("byte_stuffed_frame_receiver verification clean");
    end else begin
      $display("byte_stuffed_frame_receiver verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("byte_stuffed_frame_receiver verification failed");
    $finish;
  end

endmodule
